[hw/rtl/efsd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efsd_pkg
// Shared types and constants for the earliest-free-server dispatch block.
// ----------------------------------------------------------------------------
package efsd_pkg;

  localparam int unsigned SERVERS   = 128;
  localparam int unsigned IDX_W     = 7;
  localparam int unsigned TOD_W     = 17;
  localparam int unsigned MIN_W     = 10;
  localparam int unsigned SVC_W     = 16;
  localparam int unsigned ACT_W     = 8;
  localparam int unsigned TIME_W    = 26;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [TOD_W-1:0] OPEN_RST   = TOD_W'(28800);
  localparam logic [TOD_W-1:0] CLOSE_RST  = TOD_W'(61200);
  localparam logic [SVC_W-1:0] CAP_RST    = SVC_W'(3600);
  localparam logic [ACT_W-1:0] ACTIVE_RST = ACT_W'(128);
  localparam logic [SVC_W-1:0] SEC_PER_MIN = SVC_W'(60);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPEN   = 3'd0,
    REG_CLOSE  = 3'd1,
    REG_CAP    = 3'd2,
    REG_ACTIVE = 3'd3
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_LAST   = 5'b00100,
    ST_CALC   = 5'b01000,
    ST_UPDATE = 5'b10000
  } state_e;

  typedef struct packed {
    logic [TOD_W-1:0] open_time;
    logic [TOD_W-1:0] close_time;
    logic [SVC_W-1:0] service_cap;
    logic [IDX_W-1:0] last_idx;
    logic             reload;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic calc;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic rd_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[hw/rtl/efsd_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efsd_cfg
// Configuration registers and derived last server index.
// ----------------------------------------------------------------------------
module efsd_cfg
  import efsd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [TOD_W-1:0]     cfg_data_i,
  output cfg_t                      cfg_o
);

  logic [TOD_W-1:0] open_q, close_q;
  logic [SVC_W-1:0] cap_q;
  logic [ACT_W-1:0] active_q;
  logic             wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= OPEN_RST;
      close_q  <= CLOSE_RST;
      cap_q    <= CAP_RST;
      active_q <= ACTIVE_RST;
    end else if (wr) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_OPEN:   open_q   <= cfg_data_i;
        REG_CLOSE:  close_q  <= cfg_data_i;
        REG_CAP:    cap_q    <= cfg_data_i[SVC_W-1:0];
        REG_ACTIVE: active_q <= cfg_data_i[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.open_time   = open_q;
    cfg_o.close_time  = close_q;
    cfg_o.service_cap = cap_q;
    cfg_o.reload      = wr && (cfg_reg_e'(cfg_index_i) == REG_OPEN);
    if (active_q == '0) begin
      cfg_o.last_idx = '0;
    end else if (32'(active_q) > SERVERS) begin
      cfg_o.last_idx = IDX_W'(SERVERS - 1);
    end else begin
      cfg_o.last_idx = IDX_W'(active_q - ACT_W'(1));
    end
  end

endmodule
`default_nettype wire

[hw/rtl/efsd_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efsd_ctrl
// Sequencer: accept, scan free-at memory, compute start, update and emit.
// ----------------------------------------------------------------------------
module efsd_ctrl
  import efsd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd = 1'b1;
        if (status_i.rd_last) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/efsd_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efsd_dp
// Free-at memory, minimum scan, start/wait arithmetic, totals, result reg.
// ----------------------------------------------------------------------------
module efsd_dp
  import efsd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfg_t               cfg_i,
  input  wire cmd_t               cmd_i,
  output status_t                 status_o,
  input  wire logic [TOD_W-1:0]   arrival_seconds_i,
  input  wire logic [MIN_W-1:0]   service_minutes_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [IDX_W-1:0]        server_index_o,
  output logic [TIME_W-1:0]       start_seconds_o,
  output logic [TIME_W-1:0]       wait_seconds_o,
  output logic                    counted_o,
  output logic [COUNT_W-1:0]      counted_jobs_o,
  output logic [SUM_W-1:0]        total_wait_o
);

  logic [TIME_W-1:0]  mem [SERVERS];
  logic [SERVERS-1:0] vld_q;

  logic [TOD_W-1:0]   arr_q;
  logic [SVC_W-1:0]   svc_q, svc_raw;
  logic [IDX_W-1:0]   rd_idx_q, rd_sel_q, sel_q;
  logic [TIME_W-1:0]  rd_data_q, best_q, eff, start_q, wait_q, arr_ext;
  logic               rd_ok_q, rd_vld_q, first_q, out_valid_q;
  logic [COUNT_W-1:0] job_q;
  logic [SUM_W-1:0]   sum_q;
  logic [TIME_W:0]    fin_sum;
  logic [TIME_W-1:0]  fin;
  logic [SUM_W:0]     sum_add;
  logic               counted;

  assign svc_raw = SVC_W'(service_minutes_i) * SEC_PER_MIN;
  assign arr_ext = TIME_W'(arr_q);
  assign eff     = rd_ok_q ? rd_data_q : TIME_W'(cfg_i.open_time);
  assign fin_sum = {1'b0, start_q} + (TIME_W + 1)'(svc_q);
  assign fin     = fin_sum[TIME_W] ? '1 : fin_sum[TIME_W-1:0];
  assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(wait_q);
  assign counted = arr_q < cfg_i.close_time;

  assign status_o.rd_last  = rd_idx_q == cfg_i.last_idx;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;

  // free-at memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_data_q <= mem[rd_idx_q];
    end
    if (cmd_i.update) begin
      mem[sel_q] <= fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
      job_q       <= '0;
      sum_q       <= '0;
    end else begin
      rd_vld_q <= cmd_i.rd;
      if (cfg_i.reload) begin
        vld_q <= '0;
      end else if (cmd_i.update) begin
        vld_q[sel_q] <= 1'b1;
      end
      if (cmd_i.load) begin
        first_q <= 1'b1;
      end else if (rd_vld_q) begin
        first_q <= 1'b0;
      end
      if (cmd_i.update) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.update && counted) begin
        if (job_q != '1) begin
          job_q <= job_q + COUNT_W'(1);
        end
        sum_q <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      arr_q    <= arrival_seconds_i;
      svc_q    <= (svc_raw > cfg_i.service_cap) ? cfg_i.service_cap : svc_raw;
      rd_idx_q <= '0;
    end else if (cmd_i.rd) begin
      rd_idx_q <= rd_idx_q + IDX_W'(1);
    end
    if (cmd_i.rd) begin
      rd_ok_q  <= vld_q[rd_idx_q];
      rd_sel_q <= rd_idx_q;
    end
    if (rd_vld_q && (first_q || (eff < best_q))) begin
      best_q <= eff;
      sel_q  <= rd_sel_q;
    end
    if (cmd_i.calc) begin
      start_q <= (arr_ext > best_q) ? arr_ext : best_q;
      wait_q  <= ((arr_ext > best_q) ? arr_ext : best_q) - arr_ext;
    end
    if (cmd_i.update) begin
      server_index_o  <= sel_q;
      start_seconds_o <= start_q;
      wait_seconds_o  <= wait_q;
      counted_o       <= counted;
      counted_jobs_o  <= (counted && (job_q != '1)) ? job_q + COUNT_W'(1) : job_q;
      total_wait_o    <= counted ? (sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0]) : sum_q;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/earliest_free_server_dispatch.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// earliest_free_server_dispatch
// Assigns each job to the server that frees earliest and keeps wait totals.
// ----------------------------------------------------------------------------
//  channel  handshake                signals
//  in       in_valid_i / in_stall_o  arrival_seconds_i, service_minutes_i
//  out      out_valid_o/out_stall_i  server_index_o .. total_wait_o
//  cfg      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
//  Each job scans N servers, N = active servers (1..128): one free-at
//  memory read per server, then compare, calc and update steps.
//  Reset sets free-at times to open_time via per-server valid bits;
//  writing open_time clears them again. The result register lets the
//  next job scan while a result is stalled; update waits for it to drain.
// ----------------------------------------------------------------------------
module earliest_free_server_dispatch
  import efsd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [TOD_W-1:0]     arrival_seconds_i,
  input  wire logic [MIN_W-1:0]     service_minutes_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [IDX_W-1:0]          server_index_o,
  output logic [TIME_W-1:0]         start_seconds_o,
  output logic [TIME_W-1:0]         wait_seconds_o,
  output logic                      counted_o,
  output logic [COUNT_W-1:0]        counted_jobs_o,
  output logic [SUM_W-1:0]          total_wait_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [TOD_W-1:0]     cfg_data_i
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  efsd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  efsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  efsd_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .status_o          (status),
    .arrival_seconds_i (arrival_seconds_i),
    .service_minutes_i (service_minutes_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .server_index_o    (server_index_o),
    .start_seconds_o   (start_seconds_o),
    .wait_seconds_o    (wait_seconds_o),
    .counted_o         (counted_o),
    .counted_jobs_o    (counted_jobs_o),
    .total_wait_o      (total_wait_o)
  );

endmodule
`default_nettype wire
